[design/rv32ic_pkg.sv]
package rv32ic_pkg;

    typedef enum logic [4:0] {
        CLS_LUI         = 5'd0,
        CLS_AUIPC       = 5'd1,
        CLS_JAL         = 5'd2,
        CLS_JALR        = 5'd3,
        CLS_BRANCH      = 5'd4,
        CLS_LOAD        = 5'd5,
        CLS_STORE       = 5'd6,
        CLS_ALUIMM      = 5'd7,
        CLS_SHIFTIMM    = 5'd8,
        CLS_ALUREG      = 5'd9,
        CLS_FENCE       = 5'd10,
        CLS_ECALL       = 5'd11,
        CLS_EBREAK      = 5'd12,
        CLS_MUL         = 5'd13,
        CLS_DIV         = 5'd14,
        CLS_CSR         = 5'd15,
        CLS_PRIV        = 5'd16,
        CLS_FENCEI      = 5'd17,
        CLS_FLOAT       = 5'd18,
        CLS_UNSUPPORTED = 5'd19,
        CLS_INVALID     = 5'd20
    } insn_class_t;

    typedef enum logic [4:0] {
        ALU_NONE      = 5'd0,
        ALU_ADD       = 5'd1,
        ALU_SUB       = 5'd2,
        ALU_SLL       = 5'd3,
        ALU_SLT       = 5'd4,
        ALU_SLT_UNS   = 5'd5,
        ALU_XOR       = 5'd6,
        ALU_SRL       = 5'd7,
        ALU_SRA       = 5'd8,
        ALU_OR        = 5'd9,
        ALU_AND       = 5'd10,
        ALU_MUL       = 5'd11,
        ALU_MUL_HI    = 5'd12,
        ALU_MUL_HI_SU = 5'd13,
        ALU_MUL_HI_UU = 5'd14,
        ALU_DIV       = 5'd15,
        ALU_DIV_UNS   = 5'd16,
        ALU_REM       = 5'd17,
        ALU_REM_UNS   = 5'd18
    } alu_op_t;

    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_JAL      = 7'h6f;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_OP_IMM   = 7'h13;
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_MISC_MEM = 7'h0f;
    localparam logic [6:0] OPC_SYSTEM   = 7'h73;
    localparam logic [6:0] OPC_AMO      = 7'h2f;
    localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
    localparam logic [6:0] OPC_STORE_FP = 7'h27;
    localparam logic [6:0] OPC_FMADD    = 7'h43;
    localparam logic [6:0] OPC_FMSUB    = 7'h47;
    localparam logic [6:0] OPC_FNMSUB   = 7'h4b;
    localparam logic [6:0] OPC_FNMADD   = 7'h4f;
    localparam logic [6:0] OPC_OP_FP    = 7'h53;

    localparam logic [2:0] F3_ADD    = 3'd0;
    localparam logic [2:0] F3_SLL    = 3'd1;
    localparam logic [2:0] F3_SRL    = 3'd5;
    localparam logic [2:0] F3_FENCEI = 3'd1;
    localparam logic [2:0] F3_PRIV   = 3'd0;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MEXT = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [11:0] SYS_ECALL  = 12'h000;
    localparam logic [11:0] SYS_EBREAK = 12'h001;

    typedef struct packed {
        insn_class_t        insn_class;
        alu_op_t            alu_operation;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg_a;
        logic [4:0]         src_reg_b;
        logic signed [31:0] immediate;
        logic               is_invalid;
        logic               rtos_permitted;
    } decode_t;

    // Base integer op selected by funct3 (OP and OP-IMM share the mapping)
    function automatic alu_op_t base_alu_op(input logic [2:0] f3);
        alu_op_t op;
        case (f3)
            3'd0:    op = ALU_ADD;
            3'd1:    op = ALU_SLL;
            3'd2:    op = ALU_SLT;
            3'd3:    op = ALU_SLT_UNS;
            3'd4:    op = ALU_XOR;
            3'd5:    op = ALU_SRL;
            3'd6:    op = ALU_OR;
            3'd7:    op = ALU_AND;
            default: op = ALU_NONE;
        endcase
        return op;
    endfunction

    function automatic alu_op_t mext_alu_op(input logic [2:0] f3);
        alu_op_t op;
        case (f3)
            3'd0:    op = ALU_MUL;
            3'd1:    op = ALU_MUL_HI;
            3'd2:    op = ALU_MUL_HI_SU;
            3'd3:    op = ALU_MUL_HI_UU;
            3'd4:    op = ALU_DIV;
            3'd5:    op = ALU_DIV_UNS;
            3'd6:    op = ALU_REM;
            3'd7:    op = ALU_REM_UNS;
            default: op = ALU_NONE;
        endcase
        return op;
    endfunction

    function automatic logic class_permitted(input insn_class_t c);
        return (c <= CLS_ECALL) || (c == CLS_MUL) || (c == CLS_DIV);
    endfunction

endpackage

[design/rv32ic_if.sv]
interface rv32ic_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    logic [31:0] fetch_pc;

    modport source (output valid, output instr_word, output fetch_pc, input ready);
    modport sink   (input valid, input instr_word, input fetch_pc, output ready);
endinterface

interface rv32ic_result_if;
    logic               valid;
    logic               ready;
    logic [4:0]         insn_class;
    logic [4:0]         alu_operation;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [31:0] immediate;
    logic               is_invalid;
    logic               rtos_permitted;
    logic [31:0]        pc_out;

    modport source (
        output valid, output insn_class, output alu_operation, output dest_reg,
        output src_reg_a, output src_reg_b, output immediate, output is_invalid,
        output rtos_permitted, output pc_out, input ready
    );
    modport sink (
        input valid, input insn_class, input alu_operation, input dest_reg,
        input src_reg_a, input src_reg_b, input immediate, input is_invalid,
        input rtos_permitted, input pc_out, output ready
    );
endinterface

[design/rv32_instruction_classifier.sv]
// RV32IM instruction classifier. Each transaction on instr carries one instruction
// word and its PC; each transaction on result carries its class, ALU op, register
// numbers, sign-extended immediate (or shift amount), invalid and RTOS allow-list
// flags, and the PC unchanged. Two register stages (input register, then result
// register after the decode logic) lie between acceptance and result valid, and one
// instruction is taken every cycle while result is drained.
// Each stage holds its contents under backpressure, so instr.ready falls only
// once both stages are full and the result is not taken.
module rv32_instruction_classifier (
    input  logic                   clk,
    input  logic                   rst_n,
    rv32ic_instr_if.sink           instr,
    rv32ic_result_if.source        result
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [31:0]         s1_word_reg;
    logic [31:0]         s1_pc_reg;
    logic                s2_valid_reg;
    logic                s2_valid_next;
    rv32ic_pkg::decode_t s2_dec_reg;
    logic [31:0]         s2_pc_reg;

    logic                s1_ready;
    logic                s2_ready;
    logic                s1_load;
    logic                s2_load;
    rv32ic_pkg::decode_t dec;

    rv32ic_decode u_decode (
        .instr_word (s1_word_reg),
        .dec        (dec)
    );

    assign s2_ready = !s2_valid_reg || result.ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_load  = s1_ready && instr.valid;
    assign s2_load  = s2_ready && s1_valid_reg;

    always_comb
    begin
        s1_valid_next = s1_ready ? instr.valid : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_word_reg <= instr.instr_word;
            s1_pc_reg   <= instr.fetch_pc;
        end
        if (s2_load)
        begin
            s2_dec_reg <= dec;
            s2_pc_reg  <= s1_pc_reg;
        end
    end

    assign instr.ready           = s1_ready;
    assign result.valid          = s2_valid_reg;
    assign result.insn_class     = s2_dec_reg.insn_class;
    assign result.alu_operation  = s2_dec_reg.alu_operation;
    assign result.dest_reg       = s2_dec_reg.dest_reg;
    assign result.src_reg_a      = s2_dec_reg.src_reg_a;
    assign result.src_reg_b      = s2_dec_reg.src_reg_b;
    assign result.immediate      = s2_dec_reg.immediate;
    assign result.is_invalid     = s2_dec_reg.is_invalid;
    assign result.rtos_permitted = s2_dec_reg.rtos_permitted;
    assign result.pc_out         = s2_pc_reg;

endmodule

[design/rv32ic_decode.sv]
module rv32ic_decode (
    input  logic [31:0]          instr_word,
    output rv32ic_pkg::decode_t  dec
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [31:0] shamt;

    assign opc   = instr_word[6:0];
    assign f3    = instr_word[14:12];
    assign f7    = instr_word[31:25];
    assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
    assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
    assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                    instr_word[30:25], instr_word[11:8], 1'b0};
    assign imm_u = {instr_word[31:12], 12'b0};
    assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                    instr_word[20], instr_word[30:21], 1'b0};
    assign shamt = {27'b0, instr_word[24:20]};

    always_comb
    begin
        dec               = '0;
        dec.insn_class    = rv32ic_pkg::CLS_INVALID;
        dec.alu_operation = rv32ic_pkg::ALU_NONE;

        if (instr_word[1:0] != 2'b11)
        begin
            // compressed: registers stay zero
            dec.insn_class = rv32ic_pkg::CLS_UNSUPPORTED;
        end
        else
        begin
            dec.dest_reg  = instr_word[11:7];
            dec.src_reg_a = instr_word[19:15];
            dec.src_reg_b = instr_word[24:20];
            case (opc)
                rv32ic_pkg::OPC_LUI:
                begin
                    dec.insn_class = rv32ic_pkg::CLS_LUI;
                    dec.immediate  = imm_u;
                end
                rv32ic_pkg::OPC_AUIPC:
                begin
                    dec.insn_class = rv32ic_pkg::CLS_AUIPC;
                    dec.immediate  = imm_u;
                end
                rv32ic_pkg::OPC_JAL:
                begin
                    dec.insn_class = rv32ic_pkg::CLS_JAL;
                    dec.immediate  = imm_j;
                end
                rv32ic_pkg::OPC_JALR:
                begin
                    if (f3 == rv32ic_pkg::F3_ADD)
                    begin
                        dec.insn_class = rv32ic_pkg::CLS_JALR;
                        dec.immediate  = imm_i;
                    end
                end
                rv32ic_pkg::OPC_BRANCH:
                begin
                    dec.insn_class = rv32ic_pkg::CLS_BRANCH;
                    dec.immediate  = imm_b;
                end
                rv32ic_pkg::OPC_LOAD:
                begin
                    dec.insn_class = rv32ic_pkg::CLS_LOAD;
                    dec.immediate  = imm_i;
                end
                rv32ic_pkg::OPC_STORE:
                begin
                    dec.insn_class = rv32ic_pkg::CLS_STORE;
                    dec.immediate  = imm_s;
                end
                rv32ic_pkg::OPC_OP_IMM:
                begin
                    if (f3 == rv32ic_pkg::F3_SLL || f3 == rv32ic_pkg::F3_SRL)
                    begin
                        // only bit 30 picks arithmetic shift
                        dec.insn_class = rv32ic_pkg::CLS_SHIFTIMM;
                        dec.immediate  = shamt;
                        if (f3 == rv32ic_pkg::F3_SLL)
                            dec.alu_operation = rv32ic_pkg::ALU_SLL;
                        else if (instr_word[30])
                            dec.alu_operation = rv32ic_pkg::ALU_SRA;
                        else
                            dec.alu_operation = rv32ic_pkg::ALU_SRL;
                    end
                    else
                    begin
                        dec.insn_class    = rv32ic_pkg::CLS_ALUIMM;
                        dec.immediate     = imm_i;
                        dec.alu_operation = rv32ic_pkg::base_alu_op(f3);
                    end
                end
                rv32ic_pkg::OPC_OP:
                begin
                    if (f7 == rv32ic_pkg::F7_MEXT)
                    begin
                        dec.insn_class    = f3[2] ? rv32ic_pkg::CLS_DIV
                                                  : rv32ic_pkg::CLS_MUL;
                        dec.alu_operation = rv32ic_pkg::mext_alu_op(f3);
                    end
                    else if (f7 == rv32ic_pkg::F7_ALT &&
                             (f3 == rv32ic_pkg::F3_ADD || f3 == rv32ic_pkg::F3_SRL))
                    begin
                        dec.insn_class    = rv32ic_pkg::CLS_ALUREG;
                        dec.alu_operation = (f3 == rv32ic_pkg::F3_ADD)
                                            ? rv32ic_pkg::ALU_SUB : rv32ic_pkg::ALU_SRA;
                    end
                    else if (f7 == rv32ic_pkg::F7_BASE)
                    begin
                        dec.insn_class    = rv32ic_pkg::CLS_ALUREG;
                        dec.alu_operation = rv32ic_pkg::base_alu_op(f3);
                    end
                end
                rv32ic_pkg::OPC_MISC_MEM:
                begin
                    dec.insn_class = (f3 == rv32ic_pkg::F3_FENCEI)
                                     ? rv32ic_pkg::CLS_FENCEI : rv32ic_pkg::CLS_FENCE;
                end
                rv32ic_pkg::OPC_SYSTEM:
                begin
                    if (f3 == rv32ic_pkg::F3_PRIV && instr_word[11:7] == 5'd0 &&
                        instr_word[19:15] == 5'd0)
                    begin
                        if (instr_word[31:20] == rv32ic_pkg::SYS_ECALL)
                            dec.insn_class = rv32ic_pkg::CLS_ECALL;
                        else if (instr_word[31:20] == rv32ic_pkg::SYS_EBREAK)
                            dec.insn_class = rv32ic_pkg::CLS_EBREAK;
                        else
                            dec.insn_class = rv32ic_pkg::CLS_PRIV;
                    end
                    else
                    begin
                        dec.insn_class = rv32ic_pkg::CLS_CSR;
                    end
                end
                rv32ic_pkg::OPC_AMO:
                begin
                    dec.insn_class = rv32ic_pkg::CLS_UNSUPPORTED;
                end
                rv32ic_pkg::OPC_LOAD_FP, rv32ic_pkg::OPC_STORE_FP,
                rv32ic_pkg::OPC_FMADD, rv32ic_pkg::OPC_FMSUB,
                rv32ic_pkg::OPC_FNMSUB, rv32ic_pkg::OPC_FNMADD,
                rv32ic_pkg::OPC_OP_FP:
                begin
                    dec.insn_class = rv32ic_pkg::CLS_FLOAT;
                end
                default:
                begin
                    dec.insn_class = rv32ic_pkg::CLS_INVALID;
                end
            endcase
        end

        dec.is_invalid     = (dec.insn_class == rv32ic_pkg::CLS_INVALID);
        dec.rtos_permitted = rv32ic_pkg::class_permitted(dec.insn_class);
    end

endmodule

[design/rv32ic_checker.sv]
module rv32ic_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [4:0]         insn_class,
    input logic signed [31:0] immediate,
    input logic               is_invalid,
    input logic               rtos_permitted,
    input logic [31:0]        pc_out
);

    logic no_imm_class;

    assign no_imm_class = insn_class == rv32ic_pkg::CLS_ALUREG ||
                          insn_class == rv32ic_pkg::CLS_MUL ||
                          insn_class == rv32ic_pkg::CLS_DIV ||
                          insn_class == rv32ic_pkg::CLS_FENCE ||
                          insn_class == rv32ic_pkg::CLS_FENCEI ||
                          insn_class == rv32ic_pkg::CLS_ECALL ||
                          insn_class == rv32ic_pkg::CLS_EBREAK ||
                          insn_class == rv32ic_pkg::CLS_PRIV ||
                          insn_class == rv32ic_pkg::CLS_CSR ||
                          insn_class == rv32ic_pkg::CLS_FLOAT ||
                          insn_class == rv32ic_pkg::CLS_UNSUPPORTED ||
                          insn_class == rv32ic_pkg::CLS_INVALID;

    // stalled result must not change
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(insn_class) && $stable(pc_out)
                                    && $stable(immediate))
        else $error("result changed while stalled");

    a_invalid_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_invalid == (insn_class == rv32ic_pkg::CLS_INVALID))
        else $error("invalid flag disagrees with class");

    a_rtos_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rtos_permitted == (insn_class <= rv32ic_pkg::CLS_ECALL ||
                                         insn_class == rv32ic_pkg::CLS_MUL ||
                                         insn_class == rv32ic_pkg::CLS_DIV))
        else $error("allow-list flag disagrees with class");

    a_no_imm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_imm_class |-> immediate == 32'sd0)
        else $error("immediate set for a class without one");

    // pipeline of two entries: with the result stage empty, input is never refused
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty result stage");

endmodule

bind rv32_instruction_classifier rv32ic_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (instr.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .insn_class     (result.insn_class),
    .immediate      (result.immediate),
    .is_invalid     (result.is_invalid),
    .rtos_permitted (result.rtos_permitted),
    .pc_out         (result.pc_out)
);

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS   = 1325;
    localparam int PHASE_LEN      = 100;
    localparam int HOLD_MARK      = 400;
    localparam int HOLD_CYCLES    = 60;
    localparam int PAUSE_MARK     = 800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [31:0] word;
        logic [31:0] pc;
    } fetch_t;

    typedef struct packed {
        rv32ic_pkg::insn_class_t cls;
        rv32ic_pkg::alu_op_t     alu;
        logic [4:0]              rd;
        logic [4:0]              rs1;
        logic [4:0]              rs2;
        logic [31:0]             imm;
        logic                    invalid;
        logic                    permitted;
        logic [31:0]             pc;
    } decoded_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [31:0] in_word   = '0;
    logic [31:0] in_pc     = '0;
    logic        out_ready = 1'b0;

    fetch_t   fetch_queue[$];
    decoded_t pending_decodes[$];
    int       total_items  = 0;
    int       words_sent   = 0;
    int       results_seen = 0;
    int       mismatches   = 0;
    int       hold_left    = 0;
    logic     hold_done    = 1'b0;
    logic     pause_done   = 1'b0;
    int       idle_cycles  = 0;
    int       class_hits [21];

    // Hand-picked words: compressed and all-ones extremes, every class but AUIPC,
    // load and store, and the funct3/funct7 corner encodings
    logic [31:0] directed_words [26] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_F0B7,
        32'hFFFF_F06F, 32'hFFF0_8067, 32'h0000_9067, 32'hFE00_0EE3,
        32'h8000_0093, 32'hFE1F_9093, 32'h4010_D093, 32'hBFF0_D093,
        32'h4000_0033, 32'h4000_D033, 32'h4000_1033, 32'h0200_0033,
        32'h0200_F033, 32'h0FF0_000F, 32'h0000_100F, 32'h0000_0073,
        32'h0010_0073, 32'h3020_0073, 32'h0000_00F3, 32'h3052_9073,
        32'h0000_202F, 32'h0000_0053
    };

    rv32ic_instr_if  instr_ch ();
    rv32ic_result_if result_ch ();

    assign instr_ch.valid      = in_valid;
    assign instr_ch.instr_word = in_word;
    assign instr_ch.fetch_pc   = in_pc;
    assign result_ch.ready     = out_ready;

    rv32_instruction_classifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rv32ic_pkg::alu_op_t funct3_base_op(input logic [2:0] f3);
        case (f3)
            3'd0:    return rv32ic_pkg::ALU_ADD;
            3'd1:    return rv32ic_pkg::ALU_SLL;
            3'd2:    return rv32ic_pkg::ALU_SLT;
            3'd3:    return rv32ic_pkg::ALU_SLT_UNS;
            3'd4:    return rv32ic_pkg::ALU_XOR;
            3'd5:    return rv32ic_pkg::ALU_SRL;
            3'd6:    return rv32ic_pkg::ALU_OR;
            default: return rv32ic_pkg::ALU_AND;
        endcase
    endfunction

    function automatic decoded_t classify_insn(input logic [31:0] w, input logic [31:0] pc);
        decoded_t   d;
        logic [2:0] f3;
        logic [6:0] f7;
        f3    = w[14:12];
        f7    = w[31:25];
        d     = '0;
        d.cls = rv32ic_pkg::CLS_INVALID;
        d.alu = rv32ic_pkg::ALU_NONE;
        d.pc  = pc;
        if (w[1:0] != 2'b11)
        begin
            d.cls = rv32ic_pkg::CLS_UNSUPPORTED;
        end
        else
        begin
            d.rd  = w[11:7];
            d.rs1 = w[19:15];
            d.rs2 = w[24:20];
            case (w[6:0])
                rv32ic_pkg::OPC_LUI:
                begin
                    d.cls = rv32ic_pkg::CLS_LUI;
                    d.imm = {w[31:12], 12'b0};
                end
                rv32ic_pkg::OPC_AUIPC:
                begin
                    d.cls = rv32ic_pkg::CLS_AUIPC;
                    d.imm = {w[31:12], 12'b0};
                end
                rv32ic_pkg::OPC_JAL:
                begin
                    d.cls = rv32ic_pkg::CLS_JAL;
                    d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                end
                rv32ic_pkg::OPC_JALR:
                begin
                    if (f3 == rv32ic_pkg::F3_ADD)
                    begin
                        d.cls = rv32ic_pkg::CLS_JALR;
                        d.imm = {{20{w[31]}}, w[31:20]};
                    end
                end
                rv32ic_pkg::OPC_BRANCH:
                begin
                    d.cls = rv32ic_pkg::CLS_BRANCH;
                    d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                end
                rv32ic_pkg::OPC_LOAD:
                begin
                    d.cls = rv32ic_pkg::CLS_LOAD;
                    d.imm = {{20{w[31]}}, w[31:20]};
                end
                rv32ic_pkg::OPC_STORE:
                begin
                    d.cls = rv32ic_pkg::CLS_STORE;
                    d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
                end
                rv32ic_pkg::OPC_OP_IMM:
                begin
                    if (f3 == rv32ic_pkg::F3_SLL || f3 == rv32ic_pkg::F3_SRL)
                    begin
                        // only bit 30 matters for shifts, the rest of funct7 is ignored
                        d.cls = rv32ic_pkg::CLS_SHIFTIMM;
                        d.imm = {27'b0, w[24:20]};
                        if (f3 == rv32ic_pkg::F3_SLL)
                            d.alu = rv32ic_pkg::ALU_SLL;
                        else if (w[30])
                            d.alu = rv32ic_pkg::ALU_SRA;
                        else
                            d.alu = rv32ic_pkg::ALU_SRL;
                    end
                    else
                    begin
                        d.cls = rv32ic_pkg::CLS_ALUIMM;
                        d.imm = {{20{w[31]}}, w[31:20]};
                        d.alu = funct3_base_op(f3);
                    end
                end
                rv32ic_pkg::OPC_OP:
                begin
                    if (f7 == rv32ic_pkg::F7_MEXT)
                    begin
                        if (f3[2])
                            d.cls = rv32ic_pkg::CLS_DIV;
                        else
                            d.cls = rv32ic_pkg::CLS_MUL;
                        case (f3)
                            3'd0:    d.alu = rv32ic_pkg::ALU_MUL;
                            3'd1:    d.alu = rv32ic_pkg::ALU_MUL_HI;
                            3'd2:    d.alu = rv32ic_pkg::ALU_MUL_HI_SU;
                            3'd3:    d.alu = rv32ic_pkg::ALU_MUL_HI_UU;
                            3'd4:    d.alu = rv32ic_pkg::ALU_DIV;
                            3'd5:    d.alu = rv32ic_pkg::ALU_DIV_UNS;
                            3'd6:    d.alu = rv32ic_pkg::ALU_REM;
                            default: d.alu = rv32ic_pkg::ALU_REM_UNS;
                        endcase
                    end
                    else if (f7 == rv32ic_pkg::F7_ALT &&
                             (f3 == rv32ic_pkg::F3_ADD || f3 == rv32ic_pkg::F3_SRL))
                    begin
                        d.cls = rv32ic_pkg::CLS_ALUREG;
                        if (f3 == rv32ic_pkg::F3_ADD)
                            d.alu = rv32ic_pkg::ALU_SUB;
                        else
                            d.alu = rv32ic_pkg::ALU_SRA;
                    end
                    else if (f7 == rv32ic_pkg::F7_BASE)
                    begin
                        d.cls = rv32ic_pkg::CLS_ALUREG;
                        d.alu = funct3_base_op(f3);
                    end
                end
                rv32ic_pkg::OPC_MISC_MEM:
                begin
                    if (f3 == rv32ic_pkg::F3_FENCEI)
                        d.cls = rv32ic_pkg::CLS_FENCEI;
                    else
                        d.cls = rv32ic_pkg::CLS_FENCE;
                end
                rv32ic_pkg::OPC_SYSTEM:
                begin
                    if (f3 == rv32ic_pkg::F3_PRIV && d.rd == 5'd0 && d.rs1 == 5'd0)
                    begin
                        if (w[31:20] == rv32ic_pkg::SYS_ECALL)
                            d.cls = rv32ic_pkg::CLS_ECALL;
                        else if (w[31:20] == rv32ic_pkg::SYS_EBREAK)
                            d.cls = rv32ic_pkg::CLS_EBREAK;
                        else
                            d.cls = rv32ic_pkg::CLS_PRIV;
                    end
                    else
                    begin
                        d.cls = rv32ic_pkg::CLS_CSR;
                    end
                end
                rv32ic_pkg::OPC_AMO:
                    d.cls = rv32ic_pkg::CLS_UNSUPPORTED;
                rv32ic_pkg::OPC_LOAD_FP, rv32ic_pkg::OPC_STORE_FP,
                rv32ic_pkg::OPC_FMADD, rv32ic_pkg::OPC_FMSUB,
                rv32ic_pkg::OPC_FNMSUB, rv32ic_pkg::OPC_FNMADD,
                rv32ic_pkg::OPC_OP_FP:
                    d.cls = rv32ic_pkg::CLS_FLOAT;
                default: ;
            endcase
        end
        d.invalid   = (d.cls == rv32ic_pkg::CLS_INVALID);
        d.permitted = (d.cls <= rv32ic_pkg::CLS_ECALL) || (d.cls == rv32ic_pkg::CLS_MUL)
                      || (d.cls == rv32ic_pkg::CLS_DIV);
        return d;
    endfunction

    // Mostly well-formed encodings with random content, some raw noise and
    // compressed words
    function automatic logic [31:0] random_insn_word();
        logic [31:0] w;
        int          pick;
        w    = $urandom;
        pick = $urandom_range(99);
        if (pick < 10)
            return w;
        if (pick < 16)
        begin
            w[1:0] = 2'($urandom_range(2));
            return w;
        end
        case ($urandom_range(21))
            0:       w[6:0] = rv32ic_pkg::OPC_LUI;
            1:       w[6:0] = rv32ic_pkg::OPC_AUIPC;
            2:       w[6:0] = rv32ic_pkg::OPC_JAL;
            3:       w[6:0] = rv32ic_pkg::OPC_JALR;
            4:       w[6:0] = rv32ic_pkg::OPC_BRANCH;
            5:       w[6:0] = rv32ic_pkg::OPC_LOAD;
            6:       w[6:0] = rv32ic_pkg::OPC_STORE;
            7:       w[6:0] = rv32ic_pkg::OPC_MISC_MEM;
            8:       w[6:0] = rv32ic_pkg::OPC_SYSTEM;
            9:       w[6:0] = rv32ic_pkg::OPC_AMO;
            10:      w[6:0] = rv32ic_pkg::OPC_LOAD_FP;
            11:      w[6:0] = rv32ic_pkg::OPC_STORE_FP;
            12:      w[6:0] = rv32ic_pkg::OPC_FMADD;
            13:      w[6:0] = rv32ic_pkg::OPC_FMSUB;
            14:      w[6:0] = rv32ic_pkg::OPC_FNMSUB;
            15:      w[6:0] = rv32ic_pkg::OPC_FNMADD;
            16:      w[6:0] = rv32ic_pkg::OPC_OP_FP;
            17, 18:  w[6:0] = rv32ic_pkg::OPC_OP_IMM;
            default: w[6:0] = rv32ic_pkg::OPC_OP;
        endcase
        if (w[6:0] == rv32ic_pkg::OPC_OP || w[6:0] == rv32ic_pkg::OPC_OP_IMM)
        begin
            case ($urandom_range(3))
                0:       w[31:25] = rv32ic_pkg::F7_BASE;
                1:       w[31:25] = rv32ic_pkg::F7_MEXT;
                2:       w[31:25] = rv32ic_pkg::F7_ALT;
                default: ;
            endcase
        end
        if (w[6:0] == rv32ic_pkg::OPC_JALR && $urandom_range(3) != 0)
            w[14:12] = rv32ic_pkg::F3_ADD;
        if (w[6:0] == rv32ic_pkg::OPC_SYSTEM && $urandom_range(1) == 1)
        begin
            w[14:12] = rv32ic_pkg::F3_PRIV;
            w[11:7]  = 5'd0;
            w[19:15] = 5'd0;
            case ($urandom_range(3))
                0:       w[31:20] = rv32ic_pkg::SYS_ECALL;
                1:       w[31:20] = rv32ic_pkg::SYS_EBREAK;
                default: ;
            endcase
        end
        return w;
    endfunction

    initial
    begin : stimulus
        fetch_t item;
        int     classes_hit;
        foreach (directed_words[i])
        begin
            item.word = directed_words[i];
            item.pc   = (i == 1) ? 32'hFFFF_FFFF : 32'(i * 4);
            fetch_queue.push_back(item);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            item.word = random_insn_word();
            item.pc   = $urandom;
            fetch_queue.push_back(item);
        end
        total_items = fetch_queue.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (words_sent != total_items)
            @(posedge clk);
        while (pending_decodes.size() != 0)
            @(posedge clk);
        // catch any stray result trailing the last one
        repeat (8) @(posedge clk);

        classes_hit = 0;
        foreach (class_hits[c])
            if (class_hits[c] != 0)
                classes_hit++;
        $display("Checked %0d results from %0d words, %0d of 21 classes hit,",
                 results_seen, total_items, classes_hit);
        $display("over free-running, sender-gap, receiver-stall and mixed phases, a hold-off and a drain.");
        if (mismatches == 0 && pending_decodes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin : driver
        logic taken;
        int   sent_now;
        int   gap_pct;
        if (rst_n)
        begin
            taken    = in_valid && instr_ch.ready;
            sent_now = words_sent + (taken ? 1 : 0);
            if (taken)
            begin
                void'(fetch_queue.pop_front());
                words_sent <= sent_now;
            end
            case ((sent_now / PHASE_LEN) % 4)
                1:       gap_pct = 48;
                3:       gap_pct = 7;
                default: gap_pct = 0;
            endcase
            if (in_valid && !taken)
            begin
                // transaction still on offer, hold it
            end
            else if (fetch_queue.size() == 0)
                in_valid <= 1'b0;
            else if (sent_now == PAUSE_MARK && !pause_done && results_seen != sent_now)
                in_valid <= 1'b0;
            else if (hold_left == 0 && $urandom_range(99) < gap_pct)
                in_valid <= 1'b0;
            else
            begin
                if (sent_now == PAUSE_MARK)
                    pause_done = 1'b1;
                in_valid <= 1'b1;
                in_word  <= fetch_queue[0].word;
                in_pc    <= fetch_queue[0].pc;
            end
        end
    end

    always @(posedge clk)
    begin : receiver
        int stall_pct;
        case ((words_sent / PHASE_LEN) % 4)
            2:       stall_pct = 48;
            3:       stall_pct = 7;
            default: stall_pct = 0;
        endcase
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && words_sent >= HOLD_MARK)
        begin
            // long back-pressure so both stages fill and the input stalls
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        decoded_t want;
        logic     bad;
        if (rst_n)
        begin
            if (in_valid && instr_ch.ready)
            begin
                want = classify_insn(in_word, in_pc);
                pending_decodes.push_back(want);
                class_hits[int'(want.cls)]++;
            end
            if (result_ch.valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (pending_decodes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result transaction, pc %h", result_ch.pc_out);
                end
                else
                begin
                    want = pending_decodes.pop_front();
                    bad  = (result_ch.insn_class     !== want.cls)
                        || (result_ch.alu_operation  !== want.alu)
                        || (result_ch.dest_reg       !== want.rd)
                        || (result_ch.src_reg_a      !== want.rs1)
                        || (result_ch.src_reg_b      !== want.rs2)
                        || (result_ch.immediate      !== want.imm)
                        || (result_ch.is_invalid     !== want.invalid)
                        || (result_ch.rtos_permitted !== want.permitted)
                        || (result_ch.pc_out         !== want.pc);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("mismatch, result %0d (exp/got): class %0d/%0d alu %0d/%0d",
                                     results_seen, want.cls, result_ch.insn_class,
                                     want.alu, result_ch.alu_operation);
                            $display("  rd %0d/%0d rs1 %0d/%0d rs2 %0d/%0d imm %h/%h",
                                     want.rd, result_ch.dest_reg, want.rs1, result_ch.src_reg_a,
                                     want.rs2, result_ch.src_reg_b, want.imm, result_ch.immediate);
                            $display("  invalid %b/%b permitted %b/%b pc %h/%h",
                                     want.invalid, result_ch.is_invalid, want.permitted,
                                     result_ch.rtos_permitted, want.pc, result_ch.pc_out);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && instr_ch.ready) || (result_ch.valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

[files.f]
design/rv32ic_pkg.sv
design/rv32ic_if.sv
design/rv32ic_decode.sv
design/rv32_instruction_classifier.sv
design/rv32ic_checker.sv
test/tb.sv
